// ===== rtl/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, constants, command codes and types for the cubic Bezier
// easing solver.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int FRAC_BITS = 24;

  localparam int X_W   = FRAC_BITS + 1;   // unsigned Q1.F control x, tolerance
  localparam int Y_W   = FRAC_BITS + 4;   // signed Q3.F control y, result
  localparam int IN_W  = FRAC_BITS + 3;   // signed progress
  localparam int CFG_W = Y_W;
  localparam int S_W   = FRAC_BITS + 5;   // curve parameter, +-8.0
  localparam int COEF_W = FRAC_BITS + 8;  // polynomial coefficients
  localparam int ACC_W = FRAC_BITS + 20;  // polynomial accumulator
  localparam int P_W   = ACC_W + S_W;     // raw product
  localparam int DIV_STEPS = FRAC_BITS + 4;
  localparam int Q_W   = DIV_STEPS;
  localparam int R_W   = ACC_W + 5;
  localparam int SN_W  = S_W + 3;

  localparam longint DERIV_RAW = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint DERIV_FLOOR = (DERIV_RAW > 0) ? DERIV_RAW : 64'd1;

  localparam int NEWTON_STEPS_DEF = 8;
  localparam int BISECT_STEPS_DEF = 25;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL1_X   = 3'd0,
    REG_CTRL1_Y   = 3'd1,
    REG_CTRL2_X   = 3'd2,
    REG_CTRL2_Y   = 3'd3,
    REG_TOLERANCE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_MUL_HI,
    OP_ADD,
    OP_SAVE_E,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEWTON_UPD,
    OP_BIS_INIT,
    OP_BIS_UPD,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    MSRC_AX,
    MSRC_AX3,
    MSRC_AY,
    MSRC_ACC
  } msrc_e;

  typedef enum logic [2:0] {
    ASRC_BX,
    ASRC_BX2,
    ASRC_BY,
    ASRC_CX,
    ASRC_CY,
    ASRC_ZERO,
    ASRC_NEG_X
  } asrc_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_NPOLY,
    S_NCHK,
    S_NDER,
    S_DCHK,
    S_DINIT,
    S_DIV,
    S_NUPD,
    S_BINIT,
    S_BTEST,
    S_BPOLY,
    S_BCHK,
    S_BUPD,
    S_YPOLY,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e   op;
    msrc_e msrc;
    asrc_e asrc;
  } cmd_t;

  typedef struct packed {
    logic err_small;  // |acc| below tolerance
    logic acc_flat;   // |acc| below derivative floor
    logic bracket_ok; // lower bound below upper bound
  } sts_t;

endpackage

// ===== rtl/cbe_datapath.sv =====
// ----------------------------------------------------------------------------
// cbe_datapath
// Configuration registers, coefficient setup, shared multiply/add unit,
// radix-2 divider and the Newton / bisection update logic.
// ----------------------------------------------------------------------------
module cbe_datapath
  import cbe_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [IN_W-1:0]      progress_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic signed [Y_W-1:0]       eased_value_o
);

  localparam logic signed [S_W-1:0]   ONE_S  = S_W'(64'd1 << FRAC_BITS);
  localparam logic signed [SN_W-1:0]  S_LIM  = SN_W'(64'd8 << FRAC_BITS);
  localparam logic [Q_W:0]            Q_MAX  = (Q_W+1)'(64'd16 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'((64'd1 << (Y_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] Y_MIN  = -ACC_W'(64'd1 << (Y_W - 1));
  localparam int                      ML_W   = ACC_W / 2;
  localparam int                      MH_W   = ACC_W - ML_W;

  logic [X_W-1:0]          p1x_q, p2x_q, tol_q;
  logic signed [Y_W-1:0]   p1y_q, p2y_q;

  logic signed [COEF_W-1:0] ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
  logic signed [COEF_W-1:0] ax_d, bx_d, cx_d, ay_d, by_d, cy_d;
  logic signed [COEF_W-1:0] p1x_s, p2x_s, p1y_s, p2y_s;

  logic signed [S_W-1:0]   x_q, s_q, t0_q, t1_q;
  logic signed [S_W-1:0]   prog_ext, x_d;
  logic signed [ACC_W-1:0] acc_q, e_q;
  logic signed [P_W-1:0]   prod_q;
  logic [ACC_W-1:0]        ud_q;
  logic [R_W-1:0]          r_q;
  logic [Q_W-1:0]          q_q;
  logic                    sat_q, qneg_q;
  logic signed [Y_W-1:0]   eased_q;

  logic signed [ACC_W-1:0] mul_op, add_op, trunc_v;
  logic signed [ML_W:0]         mul_lo;
  logic signed [MH_W-1:0]       mul_hi;
  logic signed [ML_W+S_W:0]     pp_lo;
  logic signed [MH_W+S_W-1:0]   pp_hi;
  logic [ACC_W-1:0]        abs_acc, abs_e;
  logic [R_W-1:0]          div_sh;
  logic [Q_W:0]            q_mag;
  logic signed [SN_W-1:0]  q_sgn, s_new;
  logic signed [S_W-1:0]   t0_n, t1_n;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1x_q <= X_W'(64'd1 << (FRAC_BITS - 2));
      p1y_q <= Y_W'(64'd1 << (FRAC_BITS - 2));
      p2x_q <= X_W'(64'd3 << (FRAC_BITS - 2));
      p2y_q <= Y_W'(64'd3 << (FRAC_BITS - 2));
      tol_q <= X_W'(DERIV_FLOOR);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_CTRL1_X:   p1x_q <= cfg_wdata_i[X_W-1:0];
        REG_CTRL1_Y:   p1y_q <= cfg_wdata_i[Y_W-1:0];
        REG_CTRL2_X:   p2x_q <= cfg_wdata_i[X_W-1:0];
        REG_CTRL2_Y:   p2y_q <= cfg_wdata_i[Y_W-1:0];
        REG_TOLERANCE: tol_q <= cfg_wdata_i[X_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients: c = 3p1, b = 3(p2-p1) - c, a = 1 - c - b
  always_comb begin
    p1x_s = $signed(COEF_W'(p1x_q));
    p2x_s = $signed(COEF_W'(p2x_q));
    p1y_s = COEF_W'(p1y_q);
    p2y_s = COEF_W'(p2y_q);
    cx_d  = (p1x_s <<< 1) + p1x_s;
    bx_d  = ((p2x_s - p1x_s) <<< 1) + (p2x_s - p1x_s) - cx_d;
    ax_d  = COEF_W'(ONE_S) - cx_d - bx_d;
    cy_d  = (p1y_s <<< 1) + p1y_s;
    by_d  = ((p2y_s - p1y_s) <<< 1) + (p2y_s - p1y_s) - cy_d;
    ay_d  = COEF_W'(ONE_S) - cy_d - by_d;
  end

  // clamp progress to [0, 1]
  always_comb begin
    prog_ext = S_W'(progress_i);
    if (prog_ext < 0) begin
      x_d = '0;
    end else if (prog_ext > ONE_S) begin
      x_d = ONE_S;
    end else begin
      x_d = prog_ext;
    end
  end

  always_comb begin
    case (cmd_i.msrc)
      MSRC_AX:  mul_op = ACC_W'(ax_q);
      MSRC_AX3: mul_op = (ACC_W'(ax_q) <<< 1) + ACC_W'(ax_q);
      MSRC_AY:  mul_op = ACC_W'(ay_q);
      default:  mul_op = acc_q;
    endcase
    case (cmd_i.asrc)
      ASRC_BX:    add_op = ACC_W'(bx_q);
      ASRC_BX2:   add_op = ACC_W'(bx_q) <<< 1;
      ASRC_BY:    add_op = ACC_W'(by_q);
      ASRC_CX:    add_op = ACC_W'(cx_q);
      ASRC_CY:    add_op = ACC_W'(cy_q);
      ASRC_NEG_X: add_op = -ACC_W'(x_q);
      default:    add_op = '0;
    endcase
  end

  // split the multiplicand: unsigned low half first, signed high half next
  assign mul_lo = $signed({1'b0, mul_op[ML_W-1:0]});
  assign mul_hi = mul_op[ACC_W-1:ML_W];
  assign pp_lo  = mul_lo * s_q;
  assign pp_hi  = mul_hi * s_q;

  // drop fraction bits, rounding toward zero
  assign trunc_v = ACC_W'(prod_q >>> FRAC_BITS)
                 + ((prod_q[P_W-1] && (|prod_q[FRAC_BITS-1:0])) ? ACC_W'(1) : ACC_W'(0));

  assign abs_acc = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign abs_e   = e_q[ACC_W-1] ? ACC_W'(-e_q) : ACC_W'(e_q);
  assign div_sh  = R_W'(ud_q) << 3;

  always_comb begin
    q_mag = sat_q ? Q_MAX : (Q_W+1)'(q_q);
    q_sgn = qneg_q ? -SN_W'(q_mag) : SN_W'(q_mag);
    s_new = SN_W'(s_q) - q_sgn;
    if (s_new > S_LIM) begin
      s_new = S_LIM;
    end else if (s_new < -S_LIM) begin
      s_new = -S_LIM;
    end
    // x above the curve value: raise the lower bound
    if (acc_q[ACC_W-1]) begin
      t0_n = s_q;
      t1_n = t1_q;
    end else begin
      t0_n = t0_q;
      t1_n = s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q  <= x_d;
        s_q  <= x_d;
        ax_q <= ax_d;
        bx_q <= bx_d;
        cx_q <= cx_d;
        ay_q <= ay_d;
        by_q <= by_d;
        cy_q <= cy_d;
      end
      OP_MUL: prod_q <= P_W'(pp_lo);
      OP_MUL_HI: prod_q <= prod_q + (P_W'(pp_hi) <<< ML_W);
      OP_ADD: acc_q <= trunc_v + add_op;
      OP_SAVE_E: e_q <= acc_q;
      OP_DIV_INIT: begin
        ud_q   <= abs_acc;
        r_q    <= R_W'(abs_e);
        q_q    <= '0;
        sat_q  <= R_W'(abs_e) >= (R_W'(abs_acc) << 4);
        qneg_q <= e_q[ACC_W-1] ^ acc_q[ACC_W-1];
      end
      OP_DIV_STEP: begin
        if (r_q >= div_sh) begin
          r_q <= (r_q - div_sh) << 1;
          q_q <= {q_q[Q_W-2:0], 1'b1};
        end else begin
          r_q <= r_q << 1;
          q_q <= {q_q[Q_W-2:0], 1'b0};
        end
      end
      OP_NEWTON_UPD: s_q <= S_W'(s_new);
      OP_BIS_INIT: begin
        s_q  <= x_q;
        t0_q <= '0;
        t1_q <= ONE_S;
      end
      OP_BIS_UPD: begin
        t0_q <= t0_n;
        t1_q <= t1_n;
        s_q  <= t0_n + ((t1_n - t0_n) >>> 1);
      end
      default: ;
    endcase
  end

  // result register, saturated to the output width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eased_q <= '0;
    end else if (cmd_i.op == OP_OUT) begin
      if (acc_q > Y_MAX) begin
        eased_q <= Y_W'(Y_MAX);
      end else if (acc_q < Y_MIN) begin
        eased_q <= Y_W'(Y_MIN);
      end else begin
        eased_q <= Y_W'(acc_q);
      end
    end
  end

  assign sts_o.err_small  = abs_acc < ACC_W'(tol_q);
  assign sts_o.acc_flat   = abs_acc < ACC_W'(DERIV_FLOOR);
  assign sts_o.bracket_ok = t0_q < t1_q;
  assign eased_value_o    = eased_q;

endmodule

// ===== rtl/cbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbe_ctrl
// Sequencer for the solver: Newton phase, bisection fallback, final curve
// evaluation. Drives one datapath command per cycle.
// ----------------------------------------------------------------------------
module cbe_ctrl
  import cbe_pkg::*;
#(
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  localparam int NIT_W = $clog2(NEWTON_STEPS + 2);
  localparam int BIT_W = $clog2(BISECT_STEPS + 2);
  localparam int DIV_W = $clog2(DIV_STEPS);

  state_e           state_q, state_d;
  logic [3:0]       ph_q, ph_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [NIT_W-1:0] nit_q, nit_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic             done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      div_q   <= '0;
      nit_q   <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      div_q   <= div_d;
      nit_q   <= nit_d;
      bit_q   <= bit_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    div_d   = div_q;
    nit_d   = nit_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    cmd_o   = '{op: OP_NOP, msrc: MSRC_ACC, asrc: ASRC_ZERO};

    // polynomial phases per term: low multiply, high multiply, add
    if (state_q == S_NPOLY || state_q == S_BPOLY || state_q == S_YPOLY ||
        state_q == S_NDER) begin
      case (ph_q) inside
        4'd0, 4'd3, 4'd6: cmd_o.op = OP_MUL;
        4'd1, 4'd4, 4'd7: cmd_o.op = OP_MUL_HI;
        default:          cmd_o.op = OP_ADD;
      endcase
      if (ph_q <= 4'd1) begin
        if (state_q == S_YPOLY) begin
          cmd_o.msrc = MSRC_AY;
        end else if (state_q == S_NDER) begin
          cmd_o.msrc = MSRC_AX3;
        end else begin
          cmd_o.msrc = MSRC_AX;
        end
      end
      case (ph_q)
        4'd2: begin
          if (state_q == S_YPOLY) begin
            cmd_o.asrc = ASRC_BY;
          end else if (state_q == S_NDER) begin
            cmd_o.asrc = ASRC_BX2;
          end else begin
            cmd_o.asrc = ASRC_BX;
          end
        end
        4'd5: cmd_o.asrc = (state_q == S_YPOLY) ? ASRC_CY : ASRC_CX;
        4'd8: cmd_o.asrc = (state_q == S_YPOLY) ? ASRC_ZERO : ASRC_NEG_X;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        // capture progress and coefficients at the transfer edge
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        ph_d     = '0;
        nit_d    = '0;
        state_d  = (NEWTON_STEPS == 0) ? S_BINIT : S_NPOLY;
      end
      S_NPOLY: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd8) begin
          ph_d    = '0;
          state_d = S_NCHK;
        end
      end
      S_NCHK: begin
        cmd_o.op = OP_SAVE_E;
        state_d  = sts_i.err_small ? S_YPOLY : S_NDER;
      end
      S_NDER: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd5) begin
          ph_d    = '0;
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        // give up on Newton when the slope is too flat
        state_d = sts_i.acc_flat ? S_BINIT : S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = OP_DIV_INIT;
        div_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        div_d    = div_q + DIV_W'(1);
        if (div_q == DIV_W'(DIV_STEPS - 1)) begin
          state_d = S_NUPD;
        end
      end
      S_NUPD: begin
        cmd_o.op = OP_NEWTON_UPD;
        nit_d    = nit_q + NIT_W'(1);
        state_d  = (nit_q == NIT_W'(NEWTON_STEPS - 1)) ? S_BINIT : S_NPOLY;
      end
      S_BINIT: begin
        cmd_o.op = OP_BIS_INIT;
        bit_d    = '0;
        ph_d     = '0;
        state_d  = S_BTEST;
      end
      S_BTEST: begin
        if (bit_q < BIT_W'(BISECT_STEPS) && sts_i.bracket_ok) begin
          state_d = S_BPOLY;
        end else begin
          state_d = S_YPOLY;
        end
      end
      S_BPOLY: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd8) begin
          ph_d    = '0;
          state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        state_d = sts_i.err_small ? S_YPOLY : S_BUPD;
      end
      S_BUPD: begin
        cmd_o.op = OP_BIS_UPD;
        bit_d    = bit_q + BIT_W'(1);
        state_d  = S_BTEST;
      end
      S_YPOLY: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd8) begin
          ph_d    = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.op = OP_OUT;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/cubic_bezier_easing_solver_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing_solver_unit
// Unit cubic Bezier timing function: maps progress t to the eased value y.
// ----------------------------------------------------------------------------
// Pulse start_i while busy_o is low to transfer one progress value; it is
// captured at that edge. The result appears on eased_value_o with done_o high
// for exactly one cycle and stays on eased_value_o until the next result;
// there is no backpressure, so capture it on the done_o cycle. The datapath
// has a single shared add unit fed by a multiplier taken in two halves, low
// half then high half, and a one-bit-per-cycle divider. Each Newton step
// checks the curve error, evaluates the derivative and divides; when Newton
// does not converge the solver bisects, and it ends with a pass over the y
// curve. A new transfer is taken in the cycle done_o is high. Configuration
// writes take effect at once and are meant for idle periods.
module cubic_bezier_easing_solver_unit
  import cbe_pkg::*;
#(
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   start_i,
  input  logic signed [IN_W-1:0] progress_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [Y_W-1:0]  eased_value_o
);

  cmd_t cmd;
  sts_t sts;

  cbe_ctrl #(
    .NEWTON_STEPS(NEWTON_STEPS),
    .BISECT_STEPS(BISECT_STEPS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  cbe_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .progress_i   (progress_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .eased_value_o(eased_value_o)
  );

endmodule

// ===== rtl/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// cbe_checker
// Port-level checks for the easing solver, bound to the top level.
// ----------------------------------------------------------------------------
module cbe_checker
  import cbe_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  done_o,
  input logic signed [Y_W-1:0] eased_value_o
);

  // a transfer always starts a busy period
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done held longer than one cycle");

  // the result only moves at the end of a busy period
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> $stable(eased_value_o))
    else $error("result changed while idle");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !done_o)
    else $error("done right after a transfer");

endmodule

bind cubic_bezier_easing_solver_unit cbe_checker u_cbe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .eased_value_o(eased_value_o)
);

// ===== tb/cbe_easing_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_easing_checker
// Tracks register writes and progress transfers into the easing solver,
// computes the eased value each transfer must produce, and compares every
// done_o strobe against the oldest outstanding value.
// ----------------------------------------------------------------------------
module cbe_easing_checker
  import cbe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   start_i,
  input  logic signed [IN_W-1:0] progress_i,
  input  logic                   busy_i,
  input  logic                   done_i,
  input  logic signed [Y_W-1:0]  eased_value_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
  localparam longint SAT_LIM = longint'(1) << 62;
  localparam longint S_LIM   = longint'(8) << FRAC_BITS;
  localparam longint Q_LIM   = longint'(16) << FRAC_BITS;
  localparam longint Y_MAX   = (longint'(1) << (Y_W - 1)) - 1;

  logic [X_W-1:0] c1x, c2x, tol;
  logic [Y_W-1:0] c1y, c2y;

  logic signed [Y_W-1:0] eased_q[$];
  int                    fails;

  assign fail_count_o = fails;
  assign pending_o    = eased_q.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clip(a + b, -SAT_LIM, SAT_LIM);
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0]    p;
    longint unsigned r;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = p >> FRAC_BITS;
    r = (p > 128'(SAT_LIM)) ? 64'(SAT_LIM) : p[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_div(longint e, longint d);
    longint unsigned ue, ud, q;
    logic [127:0]    n;
    ue = abs64(e);
    ud = abs64(d);
    if (ue / ud >= 16) begin
      q = 64'(Q_LIM);
    end else begin
      n = ({64'd0, ue} << FRAC_BITS) / {64'd0, ud};
      q = n[63:0];
    end
    return ((e < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint cubic(longint a, longint b, longint c, longint s);
    longint v;
    v = sat_add(fx_mul(a, s), b);
    v = sat_add(fx_mul(v, s), c);
    return fx_mul(v, s);
  endfunction

  function automatic longint find_param(longint x, longint eps, longint ax, longint bx,
                                        longint cx);
    longint s, lo, hi, e, d, xv;
    s  = x;
    lo = 0;
    hi = ONE_FX;
    for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
      e = sat_add(cubic(ax, bx, cx, s), -x);
      if (longint'(abs64(e)) < eps) return s;
      d = sat_add(fx_mul(sat_add(fx_mul(3 * ax, s), 2 * bx), s), cx);
      if (longint'(abs64(d)) < DERIV_FLOOR) break;
      s = clip(s - fx_div(e, d), -S_LIM, S_LIM);
    end
    s = x;
    for (int i = 0; i < BISECT_STEPS_DEF && lo < hi; i++) begin
      xv = cubic(ax, bx, cx, s);
      if (longint'(abs64(sat_add(xv, -x))) < eps) return s;
      if (x > xv) lo = s;
      else hi = s;
      s = lo + ((hi - lo) >>> 1);
    end
    return s;
  endfunction

  function automatic logic signed [Y_W-1:0] eased_of(logic signed [IN_W-1:0] t_raw);
    longint t, p1x, p2x, p1y, p2y, cx, bx, ax, cy, by, ay, s, y;
    t   = clip(longint'(t_raw), 0, ONE_FX);
    p1x = longint'(c1x);
    p2x = longint'(c2x);
    p1y = longint'($signed(c1y));
    p2y = longint'($signed(c2y));
    cx  = 3 * p1x;
    bx  = 3 * (p2x - p1x) - cx;
    ax  = ONE_FX - cx - bx;
    cy  = 3 * p1y;
    by  = 3 * (p2y - p1y) - cy;
    ay  = ONE_FX - cy - by;
    s   = find_param(t, longint'(tol), ax, bx, cx);
    y   = clip(cubic(ay, by, cy, s), -Y_MAX - 1, Y_MAX);
    return y[Y_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1x   <= X_W'(ONE_FX / 4);
      c1y   <= Y_W'(ONE_FX / 4);
      c2x   <= X_W'(ONE_FX / 4 * 3);
      c2y   <= Y_W'(ONE_FX / 4 * 3);
      tol   <= X_W'(DERIV_FLOOR);
      fails = 0;
      eased_q.delete();
    end else begin
      // compare before queueing: a new transfer may land on the done cycle
      if (done_i) begin
        if (eased_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %0d", eased_value_i);
        end else begin
          if (eased_value_i !== eased_q[0]) begin
            fails++;
            if (fails <= 10)
              $display("eased value mismatch: expected %0d, got %0d", eased_q[0],
                       eased_value_i);
          end
          void'(eased_q.pop_front());
        end
      end
      if (start_i && !busy_i) eased_q.push_back(eased_of(progress_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CTRL1_X:   c1x <= cfg_wdata_i[X_W-1:0];
          REG_CTRL1_Y:   c1y <= cfg_wdata_i[Y_W-1:0];
          REG_CTRL2_X:   c2x <= cfg_wdata_i[X_W-1:0];
          REG_CTRL2_Y:   c2y <= cfg_wdata_i[Y_W-1:0];
          REG_TOLERANCE: tol <= cfg_wdata_i[X_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the cubic Bezier easing solver with directed and random progress
// values under a series of control point and tolerance settings, with random
// sender gaps; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import cbe_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   start_i = 1'b0;
  logic signed [IN_W-1:0] progress_i = '0;
  logic                   busy_o;
  logic                   done_o;
  logic signed [Y_W-1:0]  eased_value_o;
  int                     fail_count;
  int                     pending;
  bit                     gaps_on;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cubic_bezier_easing_solver_unit u_top (.*);

  cbe_easing_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .progress_i,
    .busy_i(busy_o), .done_i(done_o), .eased_value_i(eased_value_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // hold off new transfers and wait for every outstanding result
  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // x and tolerance registers get random junk above their width
  task automatic set_curve(int p1x, int p1y, int p2x, int p2y, int tol);
    logic [CFG_W-1:0] junk;
    drain();
    junk = CFG_W'($urandom) << X_W;
    write_reg(REG_CTRL1_X, junk | CFG_W'(p1x));
    write_reg(REG_CTRL1_Y, CFG_W'(p1y));
    junk = CFG_W'($urandom) << X_W;
    write_reg(REG_CTRL2_X, junk | CFG_W'(p2x));
    write_reg(REG_CTRL2_Y, CFG_W'(p2y));
    junk = CFG_W'($urandom) << X_W;
    write_reg(REG_TOLERANCE, junk | CFG_W'(tol));
    // unmapped index must be ignored
    write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_W'($urandom));
  endtask

  task automatic send(int t);
    bit taken;
    start_i    <= 1'b1;
    progress_i <= IN_W'(t);
    taken = 1'b0;
    while (!taken) begin
      taken = !busy_o;
      @(negedge clk_i);
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i    <= 1'b0;
      progress_i <= IN_W'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  function automatic int rand_progress();
    case ($urandom_range(0, 9))
      0:       return int'($urandom);
      1:       return int'($urandom_range(0, 4)) * (ONE / 4);
      2:       return ONE + int'($urandom_range(0, 3)) - 1;
      default: return int'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic int rand_x();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return ONE;
      2:       return (1 << X_W) - 1;
      default: return $urandom_range(0, ONE);
    endcase
  endfunction

  function automatic int rand_y();
    case ($urandom_range(0, 6))
      0:       return -(1 << (Y_W - 2));
      1:       return 1 << (Y_W - 2);
      2:       return int'($urandom);
      default: return $urandom_range(0, 2 * ONE) - ONE / 2;
    endcase
  endfunction

  function automatic int rand_tol();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (1 << X_W) - 1;
      2:       return $urandom_range(1, ONE);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  initial begin
    int corners[$];
    gaps_on = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset curve first, no register writes yet
    corners = '{-(1 << (IN_W - 1)), (1 << (IN_W - 1)) - 1, 0, -1, 1, ONE, ONE + 1,
                ONE - 1, ONE / 2, ONE / 4, ONE / 4 * 3, ONE / 1000};
    foreach (corners[i]) send(corners[i]);

    // linear curve, zero tolerance: both loops run to their caps
    set_curve(0, 0, ONE, ONE, 0);
    for (int i = 0; i < 4; i++) send(int'($urandom_range(0, ONE)));
    send(ONE / 2);
    // flat x derivative at mid-curve, overshooting y
    set_curve(ONE, 1 << (Y_W - 2), 0, -(1 << (Y_W - 2)), 17);
    send(0);
    send(ONE / 2);
    send(ONE);
    // control x beyond one, huge tolerance converges at once
    set_curve((1 << X_W) - 1, -(1 << (Y_W - 2)), (1 << X_W) - 1, (1 << (Y_W - 2)) - 1,
              (1 << X_W) - 1);
    send(ONE / 3);
    send(ONE / 2);
    send(ONE);
    set_curve((1 << X_W) - 1, ONE, 0, 0, 1);
    send(ONE / 5);
    send(ONE / 7 * 6);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) gaps_on = 1'b0;
      if (ph == 0) set_curve(ONE / 4, ONE / 4, ONE / 4 * 3, ONE / 4 * 3, 17);
      else set_curve(rand_x(), rand_y(), rand_x(), rand_y(), rand_tol());
      for (int i = 0; i < 120; i++) send(rand_progress());
      start_i <= 1'b0;
    end

    start_i <= 1'b0;
    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("cubic_bezier_easing_solver_unit verification clean");
    else $display("cubic_bezier_easing_solver_unit verification failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("cubic_bezier_easing_solver_unit verification failed");
    $finish;
  end

endmodule
